// ===== sv/im2col_address_generator_defines.svh =====
// Assertion macros shared by the im2col address generator RTL.
`ifndef IM2COL_ADDRESS_GENERATOR_DEFINES_SVH
`define IM2COL_ADDRESS_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IAG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define IAG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/iag_pkg.sv =====
// Shared types, widths and limits of the im2col address generator.
package iag_pkg;

	localparam int MAX_SIDE     = 1024;
	localparam int MAX_CHANNELS = 1024;
	localparam int MAX_KERNEL   = 15;

	// Divider: side numerator magnitude over stride.
	localparam int DIV_NUM_W = 11;
	localparam int DIV_DEN_W = 4;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = 22;
	localparam int MUL_B_W = 11;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Configuration register indexes.
	localparam logic [2:0] REG_CHANNELS = 3'd0;
	localparam logic [2:0] REG_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_WIDTH    = 3'd2;
	localparam logic [2:0] REG_KERNEL   = 3'd3;
	localparam logic [2:0] REG_STRIDE   = 3'd4;
	localparam logic [2:0] REG_PAD      = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_H,
		ST_DIV_W,
		ST_ROW,
		ST_COL,
		ST_CHAN,
		ST_SUM,
		ST_ADDR,
		ST_EMIT
	} iag_state_t;

endpackage

// ===== sv/iag_div.sv =====
// Restoring divider, one quotient bit per cycle.
module iag_div
	import iag_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quo
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] dvd_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	assign trial = {rem_q, dvd_q[DIV_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract when it fits
			rem_q <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			dvd_q <= {dvd_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = dvd_q;

endmodule

// ===== sv/iag_mul.sv =====
// Shared registered multiplier used by the address sequencer.
module iag_mul
	import iag_pkg::*;
(
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] p
);

	logic [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

// ===== sv/im2col_address_generator.sv =====
// Top level of the im2col address generator: sequencer, counters and ports.
//
// Usage: program the six registers over the cfg_we/cfg_index/cfg_data port
// while the block is idle (channels, height, width, kernel, stride, padding).
// Each slave beat carries one bit, restart. A restart beat latches the output
// sides and produces the first column-matrix element; an advance beat
// produces the next one. A beat arriving after the final element, or a
// restart of an empty walk, produces no master beat.
// Sequence: an advance beat passes through ST_ROW, ST_COL, ST_CHAN, ST_SUM,
// ST_ADDR and ST_EMIT before the master register is loaded, and the next beat
// is accepted only once the sequencer is back in ST_IDLE. A restart beat first
// runs two divisions (height, then width side over stride) in ST_DIV_H and ST_DIV_W.
// s_tready is high only while the sequencer is idle, so one beat is in work
// at a time; the single shared multiplier, used four times per element,
// sets the length of the advance sequence.
// The master side is one output register: the sequencer loads it as soon as
// it is empty or being taken, so a stalled receiver holds the element and
// the next slave beat is still accepted and worked on meanwhile.
// Reset (arst_n low) restores the register defaults 1,1,1,1,1,0, clears all
// counters and marks the walk finished, so advances emit nothing until a restart.
`include "im2col_address_generator_defines.svh"

module im2col_address_generator
	import iag_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [39:0] dest_index, [69:40] src_address, [71:70] zero
	output logic        m_tuser,   // [0] is_padding
	output logic        m_tlast
);

	// configuration registers
	logic [10:0] chan_q, height_q, width_q;
	logic [3:0]  ksize_q, step_q, margin_q;

	// walk state
	logic [3:0]  kcol_q, krow_q;
	logic [9:0]  chan_idx_q;
	logic [10:0] orow_q, ocol_q;
	logic [10:0] rows_tot_q, cols_tot_q;
	logic [39:0] elem_q;
	logic        finished_q;

	// per-element scratch
	logic signed [16:0] prow_q, pcol_q;
	logic [MUL_A_W-1:0] sum_q;

	// output register
	logic        m_tvalid_q;
	logic [71:0] m_tdata_q;
	logic        m_tuser_q;
	logic        m_tlast_q;

	iag_state_t state_q, state_d;

	logic                 s_accept;
	logic                 restart;
	logic [3:0]           stride;
	logic signed [12:0]   num_h, num_w;
	logic [DIV_NUM_W-1:0] mag_h, mag_w;
	logic                 div_start, div_done;
	logic [DIV_NUM_W-1:0] div_num, div_quo;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [MUL_P_W-1:0]   mul_p;
	logic                 out_load;
	logic                 pad;
	logic                 emit_last;
	logic [29:0]          addr;
	logic [10:0]          cols_new;
	logic [3:0]           kcol_d, krow_d;
	logic [9:0]           chan_idx_d;
	logic [10:0]          orow_d, ocol_d;

	function automatic logic [10:0] side_total(input logic neg, input logic [10:0] q);
		logic [10:0] r;
		if (neg) begin
			// truncation toward zero: a small negative numerator still gives one
			r = (q == '0) ? 11'd1 : 11'd0;
		end else begin
			r = q + 11'd1;
		end
		return r;
	endfunction

	assign restart  = s_tdata[0];
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign stride   = (step_q == '0) ? 4'd1 : step_q;

	// side + 2*pad - kernel, signed
	assign num_h = $signed({2'b0, height_q}) + $signed({8'b0, margin_q, 1'b0})
		- $signed({9'b0, ksize_q});
	assign num_w = $signed({2'b0, width_q}) + $signed({8'b0, margin_q, 1'b0})
		- $signed({9'b0, ksize_q});
	assign mag_h = num_h[12] ? DIV_NUM_W'(-num_h) : num_h[DIV_NUM_W-1:0];
	assign mag_w = num_w[12] ? DIV_NUM_W'(-num_w) : num_w[DIV_NUM_W-1:0];
	assign cols_new = side_total(num_w[12], div_quo);

	iag_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (stride),
		.done   (div_done),
		.quo    (div_quo)
	);

	iag_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// padding test and source address of the current element
	assign pad = prow_q[16] || pcol_q[16]
		|| (prow_q[15:0] >= {5'b0, height_q}) || (pcol_q[15:0] >= {5'b0, width_q});
	assign addr = 30'(pcol_q[9:0]) + mul_p[29:0];

	// next-state, operand selection and counter advance
	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		div_num    = mag_w;
		mul_a      = '0;
		mul_b      = '0;
		out_load   = 1'b0;
		emit_last  = 1'b0;
		kcol_d     = kcol_q;
		krow_d     = krow_q;
		chan_idx_d = chan_idx_q;
		orow_d     = orow_q;
		ocol_d     = ocol_q;

		// innermost output column first, channel outermost
		if ({1'b0, ocol_q} + 12'd1 >= {1'b0, cols_tot_q}) begin
			ocol_d = '0;
			if ({1'b0, orow_q} + 12'd1 >= {1'b0, rows_tot_q}) begin
				orow_d = '0;
				if ({1'b0, kcol_q} + 5'd1 >= {1'b0, ksize_q}) begin
					kcol_d = '0;
					if ({1'b0, krow_q} + 5'd1 >= {1'b0, ksize_q}) begin
						krow_d = '0;
						if ({1'b0, chan_idx_q} + 11'd1 >= chan_q) begin
							chan_idx_d = '0;
							emit_last  = 1'b1;
						end else begin
							chan_idx_d = chan_idx_q + 10'd1;
						end
					end else begin
						krow_d = krow_q + 4'd1;
					end
				end else begin
					kcol_d = kcol_q + 4'd1;
				end
			end else begin
				orow_d = orow_q + 11'd1;
			end
		end else begin
			ocol_d = ocol_q + 11'd1;
		end

		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					if (restart) begin
						div_start = 1'b1;
						div_num   = mag_h;
						state_d   = ST_DIV_H;
					end else if (!finished_q) begin
						state_d = ST_ROW;
					end
				end
			end
			ST_DIV_H: begin
				if (div_done) begin
					div_start = 1'b1;
					state_d   = ST_DIV_W;
				end
			end
			ST_DIV_W: begin
				if (div_done) begin
					if ((rows_tot_q == '0) || (cols_new == '0) || (chan_q == '0)
						|| (ksize_q == '0)) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_ROW;
					end
				end
			end
			ST_ROW: begin
				// raw stride: a zero stride keeps the window in place
				mul_a   = MUL_A_W'(orow_q);
				mul_b   = MUL_B_W'(step_q);
				state_d = ST_COL;
			end
			ST_COL: begin
				mul_a   = MUL_A_W'(ocol_q);
				mul_b   = MUL_B_W'(step_q);
				state_d = ST_CHAN;
			end
			ST_CHAN: begin
				mul_a   = MUL_A_W'(chan_idx_q);
				mul_b   = height_q;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_ADDR;
			end
			ST_ADDR: begin
				mul_a   = sum_q;
				mul_b   = width_q;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// hold the operands so the product stays while the output is full
				mul_a = sum_q;
				mul_b = width_q;
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers: channels, height and width saturated on write, the rest take the low four bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q   <= 11'd1;
			height_q <= 11'd1;
			width_q  <= 11'd1;
			ksize_q  <= 4'd1;
			step_q   <= 4'd1;
			margin_q <= 4'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHANNELS: chan_q <= (cfg_data > 11'(MAX_CHANNELS)) ?
					11'(MAX_CHANNELS) : cfg_data;
				REG_HEIGHT:   height_q <= (cfg_data > 11'(MAX_SIDE)) ?
					11'(MAX_SIDE) : cfg_data;
				REG_WIDTH:    width_q <= (cfg_data > 11'(MAX_SIDE)) ?
					11'(MAX_SIDE) : cfg_data;
				REG_KERNEL:   ksize_q <= (cfg_data[3:0] > 4'(MAX_KERNEL)) ?
					4'(MAX_KERNEL) : cfg_data[3:0];
				REG_STRIDE:   step_q <= (cfg_data[3:0] > 4'(MAX_KERNEL)) ?
					4'(MAX_KERNEL) : cfg_data[3:0];
				REG_PAD:      margin_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// walk counters and output sides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kcol_q     <= '0;
			krow_q     <= '0;
			chan_idx_q <= '0;
			orow_q     <= '0;
			ocol_q     <= '0;
			rows_tot_q <= '0;
			cols_tot_q <= '0;
			elem_q     <= '0;
			finished_q <= 1'b1;
		end else begin
			if (state_q == ST_IDLE && s_accept && restart) begin
				kcol_q     <= '0;
				krow_q     <= '0;
				chan_idx_q <= '0;
				orow_q     <= '0;
				ocol_q     <= '0;
				elem_q     <= '0;
			end
			if (state_q == ST_DIV_H && div_done) begin
				rows_tot_q <= side_total(num_h[12], div_quo);
			end
			if (state_q == ST_DIV_W && div_done) begin
				cols_tot_q <= cols_new;
				finished_q <= (rows_tot_q == '0) || (cols_new == '0) || (chan_q == '0)
					|| (ksize_q == '0);
			end
			if (out_load) begin
				kcol_q     <= kcol_d;
				krow_q     <= krow_d;
				chan_idx_q <= chan_idx_d;
				orow_q     <= orow_d;
				ocol_q     <= ocol_d;
				elem_q     <= elem_q + 40'd1;
				finished_q <= emit_last;
			end
		end
	end

	// element scratch: pixel row and column, then the row-plus-plane sum
	always_ff @(posedge clk) begin
		if (state_q == ST_COL) begin
			prow_q <= $signed({13'b0, krow_q}) + $signed({2'b0, mul_p[14:0]})
				- $signed({13'b0, margin_q});
		end
		if (state_q == ST_CHAN) begin
			pcol_q <= $signed({13'b0, kcol_q}) + $signed({2'b0, mul_p[14:0]})
				- $signed({13'b0, margin_q});
		end
		if (state_q == ST_SUM) begin
			sum_q <= MUL_A_W'(mul_p[20:0]) + MUL_A_W'(prow_q[9:0]);
		end
	end

	// master output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {2'b0, (pad ? 30'd0 : addr), elem_q};
			m_tuser_q <= pad;
			m_tlast_q <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`IAG_ASSERT_IMP(a_div_in_div_state, div_done, (state_q == ST_DIV_H) || (state_q == ST_DIV_W), "divider done outside a division state")
	`IAG_ASSERT_IMP(a_pad_zero_addr, m_tvalid && m_tuser, m_tdata[69:40] == 30'd0, "padded beat carries a nonzero source address")
	`IAG_ASSERT_NXT(a_last_finishes, out_load && emit_last, finished_q, "walk not finished after its last element")
	`IAG_ASSERT_IMP(a_no_walk_when_done, state_q == ST_ROW, !finished_q, "element computed for a finished walk")

endmodule
